// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SBDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define SBDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sbda_pkg.sv
package sbda_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } dab_stat_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_t;

  typedef struct packed {
    logic busy;
  } emit_stat_t;

endpackage

// File: sv/sbda_dabble.sv
module sbda_dabble (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  mag,
  output sbda_pkg::dab_stat_t          stat
);
  import sbda_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic               done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNT_W'(VALUE_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (run) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end
  end

  assign stat.done = done;
  assign stat.bcd  = bcd;

endmodule

// File: sv/sbda_emit.sv
module sbda_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sbda_pkg::conv_t      conv,
  output sbda_pkg::emit_stat_t stat,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [5:0] char_code, [7:6] zero
  output logic                 m_tlast    // last_char
);
  import sbda_pkg::*;

  logic [BCD_W-1:0]  digits;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  lead;
  logic              neg_pend;
  logic              busy;
  logic              out_free;
  logic [3:0]        cur_digit;
  logic [CHAR_W-1:0] char_code;

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    lead = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (conv.bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign cur_digit = digits[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy     <= 1'b1;
        neg_pend <= conv.neg;
      end else if (busy && out_free) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else if (idx == '0) begin
          busy <= 1'b0;
        end
      end
      if (busy && out_free && !load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits <= conv.bcd;
      idx    <= lead;
    end else if (busy && out_free) begin
      m_tdata <= {2'b00, char_code};
      m_tlast <= !neg_pend && (idx == '0);
      if (!neg_pend && (idx != '0)) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  assign char_code = neg_pend ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(cur_digit));
  assign stat.busy = busy;

endmodule

// File: sv/signed_binary_to_decimal_ascii_unit.sv
// Channel  Dir  Bus             Fields (low bit up)
// s_       in   s_tdata[31:0]   value (signed)
// m_       out  m_tdata[7:0]    char_code [5:0], zero [7:6]; m_tlast = last_char
// For n characters (1 to 11), an item takes 32 shift-and-add-3 steps of the BCD unit, then
// one character per cycle while m_tready stays high.
// s_tready is high only while idle; a stalled m_tready holds the character register.
// Synchronous active-high rst clears the sequencer and the output valid.
`include "assert_macros.svh"

module signed_binary_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // char_code, two zero bits
  output logic        m_tlast    // last_char
);
  import sbda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               neg;
  logic               accept;
  logic               emit_load;
  logic [VALUE_W-1:0] mag;
  dab_stat_t          dab_stat;
  emit_stat_t         emit_stat;
  conv_t              conv;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign emit_load = (state == ST_CONV) && dab_stat.done;
  assign mag       = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (dab_stat.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_stat.busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= s_tdata[31];
    end
  end

  assign conv.neg = neg;
  assign conv.bcd = dab_stat.bcd;

  sbda_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .stat  (dab_stat)
  );

  sbda_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (emit_load),
    .conv     (conv),
    .stat     (emit_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `SBDA_ASSERT(a_idle_not_busy, (state == ST_IDLE) |-> !emit_stat.busy, "emitter busy while idle")
  `SBDA_ASSERT(a_done_in_conv, dab_stat.done |-> (state == ST_CONV), "conversion done outside CONV")
  `SBDA_ASSERT(a_minus_not_last, (m_tvalid && (m_tdata[5:0] == ASCII_MINUS)) |-> !m_tlast, "minus sign flagged last")
  `SBDA_ASSERT_NEXT(a_load_busy, emit_load, emit_stat.busy && (state == ST_EMIT), "emitter not started")

endmodule

// File: tb/decimal_text_checker.sv
`timescale 1ns / 1ps

module decimal_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // char_code [5:0], zero [7:6]
  input  logic        m_tlast,   // last_char
  output int          fail_count,
  output int          pending
);

  import sbda_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t char_q[$];
  int         fails = 0;

  function automatic void queue_decimal_text(logic [VALUE_W-1:0] raw);
    logic             neg;
    logic [31:0]      mag;
    logic [3:0]       digs [0:9];
    int               ndig;
    text_char_t       c;
    neg  = raw[VALUE_W-1];
    mag  = neg ? (32'd0 - raw) : raw;
    ndig = 0;
    if (mag == 32'd0) begin
      c.code = ASCII_ZERO;
      c.last = 1'b1;
      char_q.push_back(c);
    end else begin
      while (mag != 32'd0 && ndig < NUM_DIGITS) begin
        digs[ndig] = 4'(mag % 32'd10);
        mag        = mag / 32'd10;
        ndig++;
      end
      if (neg) begin
        c.code = ASCII_MINUS;
        c.last = 1'b0;
        char_q.push_back(c);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        c.code = ASCII_ZERO + CHAR_W'(digs[i]);
        c.last = (i == 0);
        char_q.push_back(c);
      end
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        queue_decimal_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (char_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected char tdata=%h tlast=%b", $realtime, m_tdata, m_tlast);
          fails = fails + 1;
        end else begin
          want = char_q.pop_front();
          if (m_tdata !== {2'b00, want.code} || m_tlast !== want.last) begin
            if (fails < 10)
              $display("%0t: char mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                       $realtime, {2'b00, want.code}, want.last, m_tdata, m_tlast);
            fails = fails + 1;
          end
        end
      end
    end
    pending <= char_q.size();
  end

  assign fail_count = fails;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_STALL   = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;
  int cycles;
  int burst_left;
  int stall_req;
  int stall_served;

  signed_binary_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_text_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint pow10(int k);
    longint p;
    p = 1;
    for (int i = 0; i < k; i++)
      p = p * 10;
    return p;
  endfunction

  function automatic logic [31:0] pick_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    logic   neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      3, 4, 5: begin
        n   = $urandom_range(1, 10);
        lo  = (n == 1) ? 0 : pow10(n - 1);
        hi  = pow10(n) - 1;
        if (hi > 64'sd2147483647)
          hi = 64'sd2147483647;
        mag = lo + ($urandom % (hi - lo + 1));
        return neg ? 32'(-mag) : 32'(mag);
      end
      6: begin
        mag = pow10($urandom_range(0, 9)) + longint'($urandom_range(0, 2)) - 1;
        return neg ? 32'(-mag) : 32'(mag);
      end
      7: begin
        mag = longint'($urandom_range(0, 20));
        return neg ? 32'(-mag) : 32'(mag);
      end
      8: begin
        if (neg)
          return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
    end
  endtask

  task automatic send_value(logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      idle_cycles(gap);
      burst_left = $urandom_range(1, 16);
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_text();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0)
      @(posedge clk);
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    int phase_left;
    int rx_tick;
    m_tready     = 1'b0;
    stall_served = 0;
    mode         = 0;
    phase_left   = 0;
    rx_tick      = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (stall_req != stall_served) begin
        stall_served = stall_req;
        m_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ((rx_tick % 5) != 2);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] directed [0:24];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'd1234567890, -32'sd1234567890, 32'd7, -32'sd9, 32'd1000,
                 32'h7FFF_FFFE, 32'd100000, -32'sd100000, -32'sd1000000000};
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    burst_left = 0;
    stall_req  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_value(directed[i]);
    drain_text();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100)
        stall_req = stall_req + 1;
      if (i == 200)
        drain_text();
      send_value(pick_value());
    end

    drain_text();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
